[rtl/dhxf_pkg.sv]
// Package for the Denavit-Hartenberg link transform block.
// Holds default widths, fixed-point constants, the sine series divisors and
// the types that travel through the sine chain. Depends on nothing.
package dhxf_pkg;

	localparam int ANGLE_BITS_DEF  = 16;
	localparam int FIXED_WIDTH_DEF = 32;
	localparam int FRAC_BITS       = 16;

	// Horner evaluation of the sine series through the eleventh power.
	localparam int HORNER_STEPS = 5;
	localparam int RECIP_SHIFT  = 33;
	localparam int TAYLOR_DIV [HORNER_STEPS] = '{110, 72, 42, 20, 6};

	localparam logic [30:0] PIH_Q30 = 31'd1686629713;
	localparam logic [30:0] Q30_ONE = 31'h4000_0000;
	localparam logic [16:0] TRIG_ONE = 17'h1_0000;

	// Order in which the four trigonometric values of one link are computed.
	typedef enum logic [1:0] {
		SLOT_SIN_PHI,
		SLOT_COS_PHI,
		SLOT_SIN_ALPHA,
		SLOT_COS_ALPHA
	} slot_t;

	typedef struct packed {
		logic  neg;
		slot_t slot;
	} sine_tag_t;

	// Working word of one sine evaluation, all in Q2.30.
	typedef struct packed {
		logic [30:0] t;
		logic [31:0] t2;
		logic [30:0] q;
		sine_tag_t   tag;
	} sine_word_t;

endpackage

[rtl/dhxf_if.sv]
// Channel interfaces of the Denavit-Hartenberg link transform block.
// Depends on dhxf_pkg for the default widths.
interface dhxf_link_if import dhxf_pkg::*; #(
	parameter int ANGLE_BITS  = ANGLE_BITS_DEF,
	parameter int FIXED_WIDTH = FIXED_WIDTH_DEF
) ();
	logic                          valid;
	logic                          ready;
	logic [ANGLE_BITS-1:0]         joint_angle;
	logic [ANGLE_BITS-1:0]         twist_angle;
	logic signed [FIXED_WIDTH-1:0] link_length;
	logic signed [FIXED_WIDTH-1:0] link_offset;

	modport source(output valid, joint_angle, twist_angle, link_length, link_offset,
		input ready);
	modport sink(input valid, joint_angle, twist_angle, link_length, link_offset,
		output ready);
endinterface

interface dhxf_rows_if import dhxf_pkg::*; #(
	parameter int FIXED_WIDTH = FIXED_WIDTH_DEF
) ();
	logic                          valid;
	logic                          ready;
	logic [1:0]                    row_index;
	logic signed [FIXED_WIDTH-1:0] entry_col0;
	logic signed [FIXED_WIDTH-1:0] entry_col1;
	logic signed [FIXED_WIDTH-1:0] entry_col2;
	logic signed [FIXED_WIDTH-1:0] entry_col3;
	logic                          last_row;

	modport source(output valid, row_index, entry_col0, entry_col1, entry_col2,
		entry_col3, last_row, input ready);
	modport sink(input valid, row_index, entry_col0, entry_col1, entry_col2,
		entry_col3, last_row, output ready);
endinterface

[rtl/dh_transform_matrix.sv]
// Top level of the Denavit-Hartenberg link transform block.
// Depends on dhxf_pkg, dhxf_if, dhxf_sine_chain and dhxf_assemble.
//
//   Channel  Direction  Payload                                       Transfers per link
//   link     in         joint_angle twist_angle link_length link_offset     1
//   rows     out        row_index entry_col0..3 last_row                    4
//
// A link is taken in one transfer and fed into the sine chain as four angles,
// one per cycle while the chain advances: sin and cos of the joint angle, then
// of the twist. A new link is taken in the cycle its predecessor's last angle
// enters the chain, so the four angles of a link match its four row transfers.
// Without stalls the first row is offered once the later angles have entered the
// chain and passed two scaling stages, five Horner cells of three stages each,
// two final stages, the set register and the row register.
// Reset clears all valid flags and counters; payload registers are not reset.
// When the rows sink stalls with a finished set waiting, the whole chain holds.
module dh_transform_matrix import dhxf_pkg::*; #(
	parameter int ANGLE_BITS  = ANGLE_BITS_DEF,
	parameter int FIXED_WIDTH = FIXED_WIDTH_DEF
) (
	input logic         clk,
	input logic         arst_n,
	dhxf_link_if.sink   link,
	dhxf_rows_if.source rows
);
	localparam int AB     = ANGLE_BITS;
	localparam int SIDE_W = 2 * FIXED_WIDTH;
	localparam logic [AB-1:0] QUARTER = AB'(1) << (AB - 2);

	// Sequencer that walks one link through its four angles.
	logic                   busy_q;
	slot_t                  slot_q;
	logic [AB-1:0]          phi_q, alpha_q;
	logic [SIDE_W-1:0]      side_q;
	logic                   adv;
	logic                   take;
	logic [AB-1:0]          ang;
	logic [1:0]             quad;
	logic [AB-2:0]          r_eff;
	sine_tag_t              tag;

	logic                   ch_vld;
	logic signed [17:0]     ch_sine;
	slot_t                  ch_slot;
	logic [SIDE_W-1:0]      ch_side;

	// A link is taken when the sequencer is empty or hands out its last angle now.
	assign link.ready = !busy_q || (adv && (slot_q == SLOT_COS_ALPHA));
	assign take       = link.valid && link.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			slot_q <= SLOT_SIN_PHI;
		end else if (take) begin
			busy_q <= 1'b1;
			slot_q <= SLOT_SIN_PHI;
		end else if (busy_q && adv) begin
			slot_q <= slot_t'(slot_q + 2'd1);
			if (slot_q == SLOT_COS_ALPHA)
				busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			phi_q   <= link.joint_angle;
			alpha_q <= link.twist_angle;
			side_q  <= {link.link_length, link.link_offset};
		end
	end

	// Cosine is the sine a quarter turn later; the quadrant folds the angle
	// into the first quarter and sets the sign.
	always_comb begin
		case (slot_q)
			SLOT_SIN_PHI:   ang = phi_q;
			SLOT_COS_PHI:   ang = phi_q + QUARTER;
			SLOT_SIN_ALPHA: ang = alpha_q;
			SLOT_COS_ALPHA: ang = alpha_q + QUARTER;
			default:        ang = phi_q;
		endcase
		quad     = ang[AB-1:AB-2];
		r_eff    = quad[0] ? (AB-1)'(QUARTER) - (AB-1)'(ang[AB-3:0])
		                   : (AB-1)'(ang[AB-3:0]);
		tag.neg  = quad[1];
		tag.slot = slot_q;
	end

	dhxf_sine_chain #(
		.ANGLE_BITS(AB),
		.SIDE_W    (SIDE_W)
	) u_chain (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.vld_in  (busy_q),
		.r_in    (r_eff),
		.tag_in  (tag),
		.side_in (side_q),
		.vld_out (ch_vld),
		.sine_out(ch_sine),
		.slot_out(ch_slot),
		.side_out(ch_side)
	);

	dhxf_assemble #(
		.FIXED_WIDTH(FIXED_WIDTH)
	) u_assemble (
		.clk    (clk),
		.arst_n (arst_n),
		.vld_in (ch_vld),
		.sine_in(ch_sine),
		.slot_in(ch_slot),
		.side_in(ch_side),
		.adv    (adv),
		.rows   (rows)
	);

	// A taken link always starts at its first angle in the next cycle.
	a_take_start: assert property (@(posedge clk) disable iff (!arst_n)
		take |=> busy_q && (slot_q == SLOT_SIN_PHI))
		else $error("link transfer did not restart the angle sequence");

	// The sequencer walks its angles in order while the chain moves.
	a_slot_step: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && adv && !take && (slot_q != SLOT_COS_ALPHA))
		|=> busy_q && (slot_q == slot_t'($past(slot_q) + 2'd1)))
		else $error("angle sequence skipped or repeated a step");

	// A stalled chain keeps the current angle in place.
	a_slot_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && !adv) |=> busy_q && $stable(slot_q))
		else $error("angle sequence moved during a stall");
endmodule

[rtl/dhxf_horner_cell.sv]
// One Horner step of the sine series: q <= 1 - floor(t2*q) / DIVISOR, in Q2.30.
// Three stages: product, reciprocal estimate, correction. Depends on dhxf_pkg.
module dhxf_horner_cell import dhxf_pkg::*; #(
	parameter int DIVISOR = 6,
	parameter int SIDE_W  = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              adv,
	input  logic              vld_in,
	input  sine_word_t        word_in,
	input  logic [SIDE_W-1:0] side_in,
	output logic              vld_out,
	output sine_word_t        word_out,
	output logic [SIDE_W-1:0] side_out
);
	localparam logic [30:0] RECIP = 31'((64'd1 << RECIP_SHIFT) / DIVISOR);
	localparam logic [6:0]  DIV_W = 7'(DIVISOR);

	logic              v_s1, v_s2, v_s3;
	sine_word_t        w_s1, w_s2, w_s3;
	logic [SIDE_W-1:0] side_s1, side_s2, side_s3;
	logic [31:0]       x_s1, x_s2;
	logic [29:0]       est_s2;
	logic [62:0]       prod;
	logic [62:0]       est_prod;
	logic [31:0]       back;
	logic [31:0]       rem;
	logic [29:0]       quot;

	assign prod     = 63'(word_in.t2) * 63'(word_in.q);
	assign est_prod = 63'(x_s1) * 63'(RECIP);
	assign back     = 32'(est_s2) * 32'(DIV_W);
	assign rem      = x_s2 - back;
	// The estimate is low by at most one, so one compare settles the quotient.
	assign quot     = (rem >= 32'(DIV_W)) ? est_s2 + 30'd1 : est_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s1 <= vld_in;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			w_s1    <= word_in;
			side_s1 <= side_in;
			x_s1    <= prod[61:30];
			w_s2    <= w_s1;
			side_s2 <= side_s1;
			x_s2    <= x_s1;
			est_s2  <= est_prod[62:33];
			w_s3.t    <= w_s2.t;
			w_s3.t2   <= w_s2.t2;
			w_s3.tag  <= w_s2.tag;
			w_s3.q    <= Q30_ONE - {1'b0, quot};
			side_s3   <= side_s2;
		end
	end

	assign vld_out  = v_s3;
	assign word_out = w_s3;
	assign side_out = side_s3;
endmodule

[rtl/dhxf_sine_chain.sv]
// Sine of a reduced angle: scaling to Q2.30, squaring, a row of Horner cells,
// the final product and rounding to 16 fraction bits. Depends on dhxf_pkg and
// dhxf_horner_cell.
module dhxf_sine_chain import dhxf_pkg::*; #(
	parameter int ANGLE_BITS = ANGLE_BITS_DEF,
	parameter int SIDE_W     = 64
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  adv,
	input  logic                  vld_in,
	input  logic [ANGLE_BITS-2:0] r_in,
	input  sine_tag_t             tag_in,
	input  logic [SIDE_W-1:0]     side_in,
	output logic                  vld_out,
	output logic signed [17:0]    sine_out,
	output slot_t                 slot_out,
	output logic [SIDE_W-1:0]     side_out
);
	logic                  v_p1, v_p2, v_f1, v_f2;
	logic [30:0]           t_p1;
	sine_tag_t             tag_p1, tag_f1, tag_f2;
	logic [SIDE_W-1:0]     side_p1, side_p2, side_f1, side_f2;
	sine_word_t            w_p2;
	logic [31:0]           s_f1;
	logic signed [17:0]    val_f2;
	logic [ANGLE_BITS+29:0] t_prod;
	logic [61:0]           sq_prod;
	logic [61:0]           s_prod;
	logic [32:0]           rnd;
	logic [18:0]           mag;
	logic [16:0]           lim;

	logic              cv   [HORNER_STEPS+1];
	sine_word_t        cw   [HORNER_STEPS+1];
	logic [SIDE_W-1:0] cs   [HORNER_STEPS+1];

	assign t_prod  = (ANGLE_BITS+30)'(r_in) * (ANGLE_BITS+30)'(PIH_Q30);
	assign sq_prod = 62'(t_p1) * 62'(t_p1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_p1 <= 1'b0;
			v_p2 <= 1'b0;
			v_f1 <= 1'b0;
			v_f2 <= 1'b0;
		end else if (adv) begin
			v_p1 <= vld_in;
			v_p2 <= v_p1;
			v_f1 <= cv[HORNER_STEPS];
			v_f2 <= v_f1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			t_p1     <= t_prod[ANGLE_BITS+28:ANGLE_BITS-2];
			tag_p1   <= tag_in;
			side_p1  <= side_in;
			w_p2.t   <= t_p1;
			w_p2.t2  <= sq_prod[61:30];
			w_p2.q   <= Q30_ONE;
			w_p2.tag <= tag_p1;
			side_p2  <= side_p1;
		end
	end

	assign cv[0] = v_p2;
	assign cw[0] = w_p2;
	assign cs[0] = side_p2;

	for (genvar k = 0; k < HORNER_STEPS; k++) begin : g_cell
		dhxf_horner_cell #(
			.DIVISOR(TAYLOR_DIV[k]),
			.SIDE_W (SIDE_W)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.adv     (adv),
			.vld_in  (cv[k]),
			.word_in (cw[k]),
			.side_in (cs[k]),
			.vld_out (cv[k+1]),
			.word_out(cw[k+1]),
			.side_out(cs[k+1])
		);
	end

	assign s_prod = 62'(cw[HORNER_STEPS].t) * 62'(cw[HORNER_STEPS].q);
	assign rnd    = 33'(s_f1) + 33'd8192;
	assign mag    = rnd[32:14];
	assign lim    = (mag > 19'(TRIG_ONE)) ? TRIG_ONE : mag[16:0];

	always_ff @(posedge clk) begin
		if (adv) begin
			s_f1    <= s_prod[61:30];
			tag_f1  <= cw[HORNER_STEPS].tag;
			side_f1 <= cs[HORNER_STEPS];
			val_f2  <= tag_f1.neg ? -$signed({1'b0, lim}) : $signed({1'b0, lim});
			tag_f2  <= tag_f1;
			side_f2 <= side_f1;
		end
	end

	assign vld_out  = v_f2;
	assign sine_out = val_f2;
	assign slot_out = tag_f2.slot;
	assign side_out = side_f2;
endmodule

[rtl/dhxf_assemble.sv]
// Gathers the four trigonometric values of one link, forms the saturated
// products and sends the matrix one row per transfer. Depends on dhxf_pkg and dhxf_if.
module dhxf_assemble import dhxf_pkg::*; #(
	parameter int FIXED_WIDTH = FIXED_WIDTH_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     vld_in,
	input  logic signed [17:0]       sine_in,
	input  slot_t                    slot_in,
	input  logic [2*FIXED_WIDTH-1:0] side_in,
	output logic                     adv,
	dhxf_rows_if.source              rows
);
	localparam int FW = FIXED_WIDTH;
	localparam logic signed [FW-1:0] FX_MAX = {1'b0, {(FW-1){1'b1}}};
	localparam logic signed [FW-1:0] FX_MIN = {1'b1, {(FW-1){1'b0}}};
	localparam logic signed [FW-1:0] FX_ONE = FW'(18'sd65536);

	function automatic logic signed [FW-1:0] fx_mul(input logic signed [FW-1:0] x,
		input logic signed [17:0] y);
		logic [FW-1:0]  ax;
		logic [16:0]    ay;
		logic [FW+16:0] p;
		logic [FW:0]    m;
		logic           neg;
		ax  = x[FW-1] ? FW'(-x) : FW'(x);
		ay  = y[17] ? 17'(-y) : 17'(y);
		p   = (FW+17)'(ax) * (FW+17)'(ay) + (FW+17)'(1 << (FRAC_BITS - 1));
		m   = p[FW+16:FRAC_BITS];
		neg = x[FW-1] ^ y[17];
		if (neg)
			return (m > {2'b01, {(FW-1){1'b0}}}) ? FX_MIN : FW'(-m);
		else
			return (m > {1'b0, FX_MAX}) ? FX_MAX : FW'(m);
	endfunction

	logic signed [17:0]    sp_q, cp_q, sa_q;
	logic                  set_vld_q;
	logic signed [17:0]    set_sp_q, set_cp_q, set_sa_q, set_ca_q;
	logic signed [FW-1:0]  set_a_q, set_d_q;
	logic                  em_busy_q;
	logic [1:0]            row_q;
	logic signed [FW-1:0]  e_cp_q, e_sp_q, e_sa_q, e_ca_q, e_d_q;
	logic signed [FW-1:0]  e01_q, e02_q, e03_q, e11_q, e12_q, e13_q;
	logic                  em_done;
	logic                  em_free;
	logic                  load_em;

	assign em_done = rows.valid && rows.ready && (row_q == 2'd3);
	assign em_free = !em_busy_q || em_done;
	assign load_em = set_vld_q && em_free;
	assign adv     = !set_vld_q || load_em;

	always_ff @(posedge clk) begin
		if (adv && vld_in) begin
			case (slot_in)
				SLOT_SIN_PHI:   sp_q <= sine_in;
				SLOT_COS_PHI:   cp_q <= sine_in;
				SLOT_SIN_ALPHA: sa_q <= sine_in;
				SLOT_COS_ALPHA: begin
					set_sp_q <= sp_q;
					set_cp_q <= cp_q;
					set_sa_q <= sa_q;
					set_ca_q <= sine_in;
					set_a_q  <= side_in[2*FW-1:FW];
					set_d_q  <= side_in[FW-1:0];
				end
				default: ;
			endcase
		end
		if (load_em) begin
			e_cp_q <= FW'(set_cp_q);
			e_sp_q <= FW'(set_sp_q);
			e_sa_q <= FW'(set_sa_q);
			e_ca_q <= FW'(set_ca_q);
			e_d_q  <= set_d_q;
			e01_q  <= -fx_mul(FW'(set_sp_q), set_ca_q);
			e02_q  <= fx_mul(FW'(set_sp_q), set_sa_q);
			e03_q  <= fx_mul(set_a_q, set_cp_q);
			e11_q  <= fx_mul(FW'(set_cp_q), set_ca_q);
			e12_q  <= -fx_mul(FW'(set_cp_q), set_sa_q);
			e13_q  <= fx_mul(set_a_q, set_sp_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			set_vld_q <= 1'b0;
			em_busy_q <= 1'b0;
			row_q     <= 2'd0;
		end else begin
			if (adv)
				set_vld_q <= vld_in && (slot_in == SLOT_COS_ALPHA);
			if (load_em) begin
				em_busy_q <= 1'b1;
				row_q     <= 2'd0;
			end else if (rows.valid && rows.ready) begin
				row_q <= row_q + 2'd1;
				if (row_q == 2'd3)
					em_busy_q <= 1'b0;
			end
		end
	end

	always_comb begin
		rows.valid     = em_busy_q;
		rows.row_index = row_q;
		rows.last_row  = (row_q == 2'd3);
		case (row_q)
			2'd0: begin
				rows.entry_col0 = e_cp_q;
				rows.entry_col1 = e01_q;
				rows.entry_col2 = e02_q;
				rows.entry_col3 = e03_q;
			end
			2'd1: begin
				rows.entry_col0 = e_sp_q;
				rows.entry_col1 = e11_q;
				rows.entry_col2 = e12_q;
				rows.entry_col3 = e13_q;
			end
			2'd2: begin
				rows.entry_col0 = '0;
				rows.entry_col1 = e_sa_q;
				rows.entry_col2 = e_ca_q;
				rows.entry_col3 = e_d_q;
			end
			default: begin
				rows.entry_col0 = '0;
				rows.entry_col1 = '0;
				rows.entry_col2 = '0;
				rows.entry_col3 = FX_ONE;
			end
		endcase
	end

	a_set_held: assert property (@(posedge clk) disable iff (!arst_n)
		(set_vld_q && !em_free) |=> set_vld_q && $stable(set_ca_q))
		else $error("completed set dropped while the row sender was busy");

	a_row_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(rows.valid && !rows.ready) |=> rows.valid && $stable(row_q))
		else $error("row counter moved without a transfer");

	a_chain_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(em_busy_q && !rows.ready && set_vld_q) |-> !adv)
		else $error("sine chain advanced into a full set register");
endmodule
